FILE: rtl/core/deadline_timer_queue_defines.svh
// Assertion macros for the deadline timer queue checkers.
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtq assertion failed");

`endif

FILE: rtl/core/dtq_pkg.sv
package dtq_pkg;

    // Request function codes
    typedef enum logic [1:0] {
        FUNC_INSERT     = 2'd0,
        FUNC_RM_TAG     = 2'd1,
        FUNC_RM_TARGET  = 2'd2,
        FUNC_EXPIRE     = 2'd3
    } t_func;

    // Result kind codes
    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_SET     = 3'd1,
        KIND_UNSET   = 3'd2,
        KIND_EXPIRED = 3'd3,
        KIND_FULL    = 3'd4
    } t_kind;

    localparam int unsigned PORT_TIME_W = 48;
    localparam int unsigned TAG_W       = 16;
    localparam int unsigned TARGET_W    = 16;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic rd;
        logic step;
        logic finish;
    } t_dtq_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic skip;
        logic emit;
        logic last_step;
        logic out_free;
    } t_dtq_sts;

endpackage

FILE: rtl/core/dtq_if.sv
interface dtq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [47:0] deadline_time;
    logic [15:0] correlation_tag;
    logic [15:0] target_instance;
    logic [47:0] now_time;

    modport source (output valid, func, deadline_time, correlation_tag,
                    target_instance, now_time, input ready);
    modport sink (input valid, func, deadline_time, correlation_tag,
                  target_instance, now_time, output ready);
endinterface

interface dtq_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [47:0] out_time;
    logic [15:0] out_tag;
    logic [15:0] out_target;
    logic        last;

    modport source (output valid, kind, out_time, out_tag, out_target, last,
                    input ready);
    modport sink (input valid, kind, out_time, out_tag, out_target, last,
                  output ready);
endinterface

FILE: rtl/core/dtq_ctrl.sv
module dtq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dtq_pkg::t_dtq_sts i_sts,
    output dtq_pkg::t_dtq_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Sequencing: read an entry, evaluate it, then close the request
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.skip ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                // an expired entry waits for room in the result register
                if (!i_sts.emit || i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    n_state    = i_sts.last_step ? S_DONE : S_READ;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/dtq_dp.sv
module dtq_dp #(
    parameter int unsigned DEPTH      = 32,
    parameter int unsigned TIME_WIDTH = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtq_pkg::t_dtq_cmd i_cmd,
    output dtq_pkg::t_dtq_sts o_sts,
    input  logic [1:0]        i_func,
    input  logic [47:0]       i_deadline_time,
    input  logic [15:0]       i_correlation_tag,
    input  logic [15:0]       i_target_instance,
    input  logic [47:0]       i_now_time,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_kind,
    output logic [47:0]       o_out_time,
    output logic [15:0]       o_out_tag,
    output logic [15:0]       o_out_target,
    output logic              o_last
);

    localparam int unsigned TW = TIME_WIDTH;
    localparam int unsigned EW = TW + dtq_pkg::TAG_W + dtq_pkg::TARGET_W;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned IW = $clog2(DEPTH);

    // Entry memory: {time, tag, target}
    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rdata;

    dtq_pkg::t_func r_func;
    logic [TW-1:0]  r_time, r_now, r_first_rm, r_front;
    logic [15:0]    r_tag, r_tgt;
    logic [CW-1:0]  r_count, r_w;
    logic [IW-1:0]  r_idx, r_ins_pos;
    logic           r_found, r_prefix, r_front_drop;

    logic           r_ovalid;
    dtq_pkg::t_kind r_okind;
    logic [47:0]    r_otime;
    logic [15:0]    r_otag, r_otgt;
    logic           r_olast;

    logic [TW-1:0]  rd_time;
    logic [15:0]    rd_tag, rd_tgt;
    logic           drop, ins_move, idx_last, full, in_full;
    logic           we;
    logic [IW-1:0]  waddr;
    logic [EW-1:0]  wdata;
    dtq_pkg::t_kind fin_kind;
    logic [TW-1:0]  fin_time;

    assign rd_time = r_rdata[EW-1 -: TW];
    assign rd_tag  = r_rdata[dtq_pkg::TAG_W + dtq_pkg::TARGET_W - 1 -: dtq_pkg::TAG_W];
    assign rd_tgt  = r_rdata[dtq_pkg::TARGET_W-1:0];

    assign full     = (r_count == CW'(DEPTH));
    assign in_full  = (r_count == CW'(DEPTH));
    assign ins_move = (rd_time > r_time);
    assign idx_last = (CW'(r_idx) == r_count - CW'(1));

    // Which entry leaves the queue
    always_comb begin
        case (r_func)
            dtq_pkg::FUNC_RM_TAG:    drop = !r_found && (rd_tag == r_tag);
            dtq_pkg::FUNC_RM_TARGET: drop = (rd_tgt == r_tgt);
            dtq_pkg::FUNC_EXPIRE:    drop = r_prefix && (rd_time < r_now);
            default:                 drop = 1'b0;
        endcase
    end

    // Status toward the controller
    always_comb begin
        o_sts.skip = ((dtq_pkg::t_func'(i_func) == dtq_pkg::FUNC_INSERT) && in_full)
                     || (r_count == '0);
        o_sts.emit = (r_func == dtq_pkg::FUNC_EXPIRE) && drop;
        o_sts.last_step = (r_func == dtq_pkg::FUNC_INSERT)
                          ? (!ins_move || (r_idx == '0)) : idx_last;
        o_sts.out_free = !r_ovalid || i_ready;
    end

    // Memory write port: shift up on insert, compact on removal
    always_comb begin
        we    = 1'b0;
        waddr = r_w[IW-1:0];
        wdata = r_rdata;
        if (i_cmd.step) begin
            if (r_func == dtq_pkg::FUNC_INSERT) begin
                we    = ins_move;
                waddr = r_idx + IW'(1);
            end else begin
                we = !drop;
            end
        end else if (i_cmd.finish && (r_func == dtq_pkg::FUNC_INSERT) && !full) begin
            we    = 1'b1;
            waddr = r_ins_pos;
            wdata = {r_time, r_tag, r_tgt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    // Closing result of a request
    always_comb begin
        fin_kind = dtq_pkg::KIND_NONE;
        fin_time = r_front;
        case (r_func)
            dtq_pkg::FUNC_INSERT: begin
                fin_time = r_time;
                if (full)
                    fin_kind = dtq_pkg::KIND_FULL;
                else if (r_ins_pos == '0)
                    fin_kind = dtq_pkg::KIND_SET;
            end
            dtq_pkg::FUNC_RM_TAG: begin
                if (r_found && (r_w == '0))
                    fin_kind = dtq_pkg::KIND_UNSET;
                else if (r_found && r_front_drop)
                    fin_kind = dtq_pkg::KIND_SET;
            end
            dtq_pkg::FUNC_RM_TARGET: begin
                if (r_found && (r_w == '0))
                    fin_kind = dtq_pkg::KIND_UNSET;
                else if (r_found && (r_first_rm < r_front))
                    fin_kind = dtq_pkg::KIND_SET;
            end
            dtq_pkg::FUNC_EXPIRE: begin
                if (r_w != '0)
                    fin_kind = dtq_pkg::KIND_SET;
            end
            default: begin
                fin_kind = dtq_pkg::KIND_NONE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                if (r_func == dtq_pkg::FUNC_INSERT) begin
                    if (!full)
                        r_count <= r_count + CW'(1);
                end else begin
                    r_count <= r_w;
                end
            end
            if ((i_cmd.step && o_sts.emit) || i_cmd.finish)
                r_ovalid <= 1'b1;
            else if (i_ready)
                r_ovalid <= 1'b0;
        end
    end

    // Request and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func       <= dtq_pkg::t_func'(i_func);
            r_time       <= TW'(i_deadline_time);
            r_now        <= TW'(i_now_time);
            r_tag        <= i_correlation_tag;
            r_tgt        <= i_target_instance;
            r_idx        <= (dtq_pkg::t_func'(i_func) == dtq_pkg::FUNC_INSERT)
                            ? IW'(r_count - CW'(1)) : '0;
            r_w          <= '0;
            r_found      <= 1'b0;
            r_prefix     <= 1'b1;
            r_front_drop <= 1'b0;
            r_ins_pos    <= '0;
        end else if (i_cmd.step) begin
            if (r_func == dtq_pkg::FUNC_INSERT) begin
                if (ins_move)
                    r_idx <= r_idx - IW'(1);
                else
                    r_ins_pos <= r_idx + IW'(1);
            end else begin
                r_idx <= r_idx + IW'(1);
                if (drop) begin
                    r_found <= 1'b1;
                    if (!r_found)
                        r_first_rm <= rd_time;
                    if (r_idx == '0)
                        r_front_drop <= 1'b1;
                end else begin
                    if (r_w == '0)
                        r_front <= rd_time;
                    r_w      <= r_w + CW'(1);
                    r_prefix <= 1'b0;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && o_sts.emit) begin
            r_okind <= dtq_pkg::KIND_EXPIRED;
            r_otime <= 48'(rd_time);
            r_otag  <= rd_tag;
            r_otgt  <= rd_tgt;
            r_olast <= 1'b0;
        end else if (i_cmd.finish) begin
            r_okind <= fin_kind;
            r_otime <= (fin_kind == dtq_pkg::KIND_SET) ? 48'(fin_time) : '0;
            r_otag  <= '0;
            r_otgt  <= '0;
            r_olast <= 1'b1;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_kind       = r_okind;
    assign o_out_time   = r_otime;
    assign o_out_tag    = r_otag;
    assign o_out_target = r_otgt;
    assign o_last       = r_olast;

endmodule

FILE: rtl/core/deadline_timer_queue.sv
// A request scans n entries: every stored entry for removes and expire, and for insert
// the entries after the insert point plus the one it stops at, if any (n = 0 when empty or full).
// Requests are taken one at a time, and result-side stalls hold the scan. The entry memory
// is read and written in alternate states (read, then evaluate and write back).
// Reset clears the entry count and the result valid; the entry memory is not cleared.
module deadline_timer_queue #(
    parameter int unsigned DEPTH      = 32,
    parameter int unsigned TIME_WIDTH = 48
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtq_req_if.sink   i_req,
    dtq_res_if.source o_res
);

    dtq_pkg::t_dtq_cmd cmd;
    dtq_pkg::t_dtq_sts sts;

    dtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dtq_dp #(
        .DEPTH      (DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_func            (i_req.func),
        .i_deadline_time   (i_req.deadline_time),
        .i_correlation_tag (i_req.correlation_tag),
        .i_target_instance (i_req.target_instance),
        .i_now_time        (i_req.now_time),
        .o_valid           (o_res.valid),
        .i_ready           (o_res.ready),
        .o_kind            (o_res.kind),
        .o_out_time        (o_res.out_time),
        .o_out_tag         (o_res.out_tag),
        .o_out_target      (o_res.out_target),
        .o_last            (o_res.last)
    );

endmodule

FILE: rtl/core/dtq_chk.sv
`include "deadline_timer_queue_defines.svh"

module dtq_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_kind,
    input logic       i_last
);

    // a held result beat stays until taken
    `DTQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // one request at a time: no new beat right after one is taken
    `DTQ_ASSERT_NEXT(a_one_req, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // kind codes stay in range
    `DTQ_ASSERT_NOW(a_kind_rng, i_clk, i_rst_n, i_out_valid, i_kind <= dtq_pkg::KIND_FULL)
    // expired entries never close a request, all other kinds do
    `DTQ_ASSERT_NOW(a_last_kind, i_clk, i_rst_n, i_out_valid, (i_kind == dtq_pkg::KIND_EXPIRED) == !i_last)

endmodule

bind deadline_timer_queue dtq_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_kind      (o_res.kind),
    .i_last      (o_res.last)
);

FILE: verif/tb_deadline_timer_queue.sv
module tb_deadline_timer_queue;

    localparam int QDEPTH = 32;
    localparam int LIMIT  = 1500000;

    // Request beat as driven on the input channel
    typedef struct packed {
        dtq_pkg::t_func func;
        logic [47:0]    dl;
        logic [15:0]    tag;
        logic [15:0]    tgt;
        logic [47:0]    now;
    } t_req;

    // Result beat as expected on the output channel
    typedef struct packed {
        dtq_pkg::t_kind kind;
        logic [47:0]    tm;
        logic [15:0]    tag;
        logic [15:0]    tgt;
        logic           last;
    } t_res;

    logic i_clk;
    logic i_rst_n;

    dtq_req_if req_ch();
    dtq_res_if res_ch();

    deadline_timer_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    // Shadow copy of the sorted entries
    logic [47:0] sh_time [QDEPTH];
    logic [15:0] sh_tag  [QDEPTH];
    logic [15:0] sh_tgt  [QDEPTH];
    int          sh_count;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   errors;
    int   cycles;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_cycles;
    bit   send_pause;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Append to the stimulus and expectation queues
    function automatic void queue_req(input t_req r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic void expect_res(input t_res r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    task automatic report(input string what, input t_res got, input t_res exp);
        errors++;
        $display("MISMATCH %s: got k=%0d t=%h tag=%h tgt=%h l=%b exp k=%0d t=%h tag=%h tgt=%h l=%b",
                 what, got.kind, got.tm, got.tag, got.tgt, got.last,
                 exp.kind, exp.tm, exp.tag, exp.tgt, exp.last);
    endtask

    function automatic t_res mk(dtq_pkg::t_kind k, logic [47:0] t, logic [15:0] tg,
                                logic [15:0] tt, logic l);
        t_res r;
        r.kind = k; r.tm = t; r.tag = tg; r.tgt = tt; r.last = l;
        return r;
    endfunction

    // Apply one request to the shadow queue and queue its expected results
    task automatic predict_queue_op(input t_req rq);
        int pos, w;
        bit found;
        logic [47:0] first_rm;
        case (rq.func)
            dtq_pkg::FUNC_INSERT: begin
                if (sh_count >= QDEPTH) begin
                    expect_res(mk(dtq_pkg::KIND_FULL, 0, 0, 0, 1'b1));
                end else begin
                    pos = 0;
                    while (pos < sh_count && sh_time[pos] <= rq.dl) pos++;
                    for (int i = sh_count; i > pos; i--) begin
                        sh_time[i] = sh_time[i-1];
                        sh_tag[i]  = sh_tag[i-1];
                        sh_tgt[i]  = sh_tgt[i-1];
                    end
                    sh_time[pos] = rq.dl; sh_tag[pos] = rq.tag; sh_tgt[pos] = rq.tgt;
                    sh_count++;
                    if (pos == 0) expect_res(mk(dtq_pkg::KIND_SET, rq.dl, 0, 0, 1'b1));
                    else expect_res(mk(dtq_pkg::KIND_NONE, 0, 0, 0, 1'b1));
                end
            end
            dtq_pkg::FUNC_RM_TAG: begin
                pos = 0;
                found = 0;
                while (pos < sh_count && sh_tag[pos] != rq.tag) pos++;
                if (pos < sh_count) begin
                    found = 1;
                    for (int i = pos; i + 1 < sh_count; i++) begin
                        sh_time[i] = sh_time[i+1];
                        sh_tag[i]  = sh_tag[i+1];
                        sh_tgt[i]  = sh_tgt[i+1];
                    end
                    sh_count--;
                end
                if (!found) begin
                    expect_res(mk(dtq_pkg::KIND_NONE, 0, 0, 0, 1'b1));
                end else if (sh_count == 0) begin
                    expect_res(mk(dtq_pkg::KIND_UNSET, 0, 0, 0, 1'b1));
                end else if (pos == 0) begin
                    expect_res(mk(dtq_pkg::KIND_SET, sh_time[0], 0, 0, 1'b1));
                end else begin
                    expect_res(mk(dtq_pkg::KIND_NONE, 0, 0, 0, 1'b1));
                end
            end
            dtq_pkg::FUNC_RM_TARGET: begin
                found = 0; first_rm = 0; w = 0;
                for (int i = 0; i < sh_count; i++) begin
                    if (sh_tgt[i] == rq.tgt) begin
                        if (!found) begin
                            found = 1; first_rm = sh_time[i];
                        end
                    end else begin
                        sh_time[w] = sh_time[i]; sh_tag[w] = sh_tag[i]; sh_tgt[w] = sh_tgt[i];
                        w++;
                    end
                end
                if (!found) begin
                    expect_res(mk(dtq_pkg::KIND_NONE, 0, 0, 0, 1'b1));
                end else begin
                    sh_count = w;
                    if (w == 0) expect_res(mk(dtq_pkg::KIND_UNSET, 0, 0, 0, 1'b1));
                    else if (first_rm < sh_time[0])
                        expect_res(mk(dtq_pkg::KIND_SET, sh_time[0], 0, 0, 1'b1));
                    else expect_res(mk(dtq_pkg::KIND_NONE, 0, 0, 0, 1'b1));
                end
            end
            default: begin
                pos = 0;
                while (pos < sh_count && sh_time[pos] < rq.now) pos++;
                for (int i = 0; i < pos; i++)
                    expect_res(mk(dtq_pkg::KIND_EXPIRED, sh_time[i], sh_tag[i],
                                  sh_tgt[i], 1'b0));
                w = 0;
                for (int i = pos; i < sh_count; i++) begin
                    sh_time[w] = sh_time[i]; sh_tag[w] = sh_tag[i]; sh_tgt[w] = sh_tgt[i];
                    w++;
                end
                sh_count = w;
                if (w > 0) expect_res(mk(dtq_pkg::KIND_SET, sh_time[0], 0, 0, 1'b1));
                else expect_res(mk(dtq_pkg::KIND_NONE, 0, 0, 0, 1'b1));
            end
        endcase
    endtask

    // Driver: offers pending beats, changes at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_ch.ready) begin
            // hold the offered beat
        end else if (pending_reqs.size() > 0 && !send_pause
                     && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid           <= 1'b1;
            req_ch.func            <= pending_reqs[0].func;
            req_ch.deadline_time   <= pending_reqs[0].dl;
            req_ch.correlation_tag <= pending_reqs[0].tag;
            req_ch.target_instance <= pending_reqs[0].tgt;
            req_ch.now_time        <= pending_reqs[0].now;
            void'(pending_reqs.pop_front());
        end else begin
            req_ch.valid <= 1'b0;
        end
    end

    // Receiver ready, with a long hold-off counted here
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles  <= hold_cycles - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts on accepted requests, checks accepted results
    always @(posedge i_clk) begin
        t_req rq;
        t_res got;
        t_res exp;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                rq.func = dtq_pkg::t_func'(req_ch.func);
                rq.dl   = req_ch.deadline_time;
                rq.tag  = req_ch.correlation_tag;
                rq.tgt  = req_ch.target_instance;
                rq.now  = req_ch.now_time;
                predict_queue_op(rq);
            end
            if (res_ch.valid && res_ch.ready) begin
                got = mk(dtq_pkg::t_kind'(res_ch.kind), res_ch.out_time, res_ch.out_tag,
                         res_ch.out_target, res_ch.last);
                if (expected_results.size() == 0) begin
                    report("unexpected beat", got, got);
                end else begin
                    exp = expected_results.pop_front();
                    if (got.kind !== exp.kind) report("kind", got, exp);
                    else if (got.tm !== exp.tm) report("out_time", got, exp);
                    else if (got.tag !== exp.tag) report("out_tag", got, exp);
                    else if (got.tgt !== exp.tgt) report("out_target", got, exp);
                    else if (got.last !== exp.last) report("last", got, exp);
                end
            end
        end
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_req req_of(dtq_pkg::t_func f, logic [47:0] d, logic [15:0] tg,
                                    logic [15:0] tt, logic [47:0] n);
        t_req r;
        r.func = f; r.dl = d; r.tag = tg; r.tgt = tt; r.now = n;
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Random phase: inserts as the most common op, with small tag/target pools, mixed with removes/expires
    task automatic random_phase(input int n);
        int r;
        logic [47:0] base;
        base = rand48() >> 2;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 45)
                queue_req(req_of(dtq_pkg::FUNC_INSERT,
                    ($urandom_range(9) == 0) ? rand48() : base + $urandom_range(40),
                    ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15)),
                    ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5)),
                    rand48()));
            else if (r < 62)
                queue_req(req_of(dtq_pkg::FUNC_RM_TAG, rand48(),
                    ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(15)),
                    16'($urandom), rand48()));
            else if (r < 78)
                queue_req(req_of(dtq_pkg::FUNC_RM_TARGET, rand48(), 16'($urandom),
                    ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(5)),
                    rand48()));
            else
                queue_req(req_of(dtq_pkg::FUNC_EXPIRE, rand48(), 16'($urandom),
                    16'($urandom),
                    ($urandom_range(7) == 0) ? rand48() : base + $urandom_range(45)));
        end
    endtask

    initial begin
        errors = 0; cycles = 0; sh_count = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
        send_pause = 0;
        req_ch.valid = 1'b0; req_ch.func = dtq_pkg::FUNC_INSERT; req_ch.deadline_time = '0;
        req_ch.correlation_tag = '0; req_ch.target_instance = '0; req_ch.now_time = '0;
        res_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-queue ops, extremes, ties, front changes, full queue
        queue_req(req_of(dtq_pkg::FUNC_EXPIRE, '0, '0, '0, '1));
        queue_req(req_of(dtq_pkg::FUNC_RM_TAG, '0, 16'hFFFF, '0, '0));
        queue_req(req_of(dtq_pkg::FUNC_RM_TARGET, '0, '0, 16'hFFFF, '0));
        queue_req(req_of(dtq_pkg::FUNC_INSERT, '1, 16'hFFFF, 16'hFFFF, '0));
        queue_req(req_of(dtq_pkg::FUNC_INSERT, 48'd100, 16'd1, 16'd2, '0));
        queue_req(req_of(dtq_pkg::FUNC_INSERT, 48'd100, 16'd2, 16'd3, '0));
        queue_req(req_of(dtq_pkg::FUNC_INSERT, '0, 16'd0, 16'd0, '1));
        queue_req(req_of(dtq_pkg::FUNC_RM_TAG, '0, 16'd2, '0, '0));
        queue_req(req_of(dtq_pkg::FUNC_RM_TAG, '0, 16'd0, '0, '0));
        queue_req(req_of(dtq_pkg::FUNC_RM_TAG, '0, 16'd77, '0, '0));
        queue_req(req_of(dtq_pkg::FUNC_RM_TARGET, '0, '0, 16'd9, '0));
        queue_req(req_of(dtq_pkg::FUNC_RM_TARGET, '0, '0, 16'd2, '0));
        queue_req(req_of(dtq_pkg::FUNC_EXPIRE, '0, '0, '0, 48'd100));
        queue_req(req_of(dtq_pkg::FUNC_EXPIRE, '0, '0, '0, '1));
        queue_req(req_of(dtq_pkg::FUNC_RM_TAG, '0, 16'hFFFF, '0, '0));
        for (int i = 0; i < QDEPTH + 1; i++)
            queue_req(req_of(dtq_pkg::FUNC_INSERT, 48'(1000 - i), 16'(i), 16'(i % 3), '0));
        queue_req(req_of(dtq_pkg::FUNC_RM_TARGET, '0, '0, 16'd1, '0));
        queue_req(req_of(dtq_pkg::FUNC_EXPIRE, '0, '0, '0, '1));
        wait_drained();

        // No idling
        random_phase(50);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering
        hold_cycles = 400;
        random_phase(20);
        wait_drained();

        // Sender idle
        send_idle_pct = 49;
        random_phase(50);
        wait_drained();

        // Receiver stalling
        send_idle_pct = 0; recv_stall_pct = 49;
        random_phase(50);
        wait_drained();

        // Both, with a sender pause until everything has come back
        send_idle_pct = 32; recv_stall_pct = 32;
        random_phase(30);
        send_pause = 1;
        while (expected_results.size() > 0 || req_ch.valid) @(posedge i_clk);
        send_pause = 0;
        random_phase(30);
        queue_req(req_of(dtq_pkg::FUNC_EXPIRE, '0, '0, '0, '1));
        wait_drained();

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
